// ===== design/lbr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbr_pkg
// Shared constants and types for the longest valid bracket run block.
// ----------------------------------------------------------------------------
package lbr_pkg;

  localparam int          MAX_LEN_DEF = 1024;
  localparam int          SYM_W       = 8;
  localparam int          LEN_W       = 11;
  localparam logic [SYM_W-1:0] OPEN_SYMBOL = 8'h28;

  // Stack operation requested by the control logic for one beat.
  typedef struct packed {
    logic push;  // opening bracket: new entry on top
    logic pop;   // closing bracket with entries above the base
    logic load;  // closing bracket on the base alone: replace the base
  } lbr_op_t;

  // Per-cell shift command along the chain.
  typedef struct packed {
    logic shift_in;   // take the value of the neighbor toward the top
    logic shift_out;  // take the value of the neighbor toward the bottom
  } lbr_shift_t;

endpackage

// ===== design/lbr_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbr_cell
// One stack entry of the shifting position stack.
// ----------------------------------------------------------------------------
module lbr_cell #(
  parameter int W = 11
) (
  input  logic                clk,
  input  logic                clr,
  input  lbr_pkg::lbr_shift_t shift,
  input  logic [W-1:0]        prev_val,
  input  logic [W-1:0]        next_val,
  output logic [W-1:0]        data
);
  import lbr_pkg::*;

  logic [W-1:0] data_r;
  logic [W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (clr) begin
      data_nxt = '0;
    end else if (shift.shift_in) begin
      data_nxt = prev_val;
    end else if (shift.shift_out) begin
      data_nxt = next_val;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ===== design/lbr_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbr_stack
// Position stack built as a chain of cells with the top in cell zero.
// ----------------------------------------------------------------------------
module lbr_stack #(
  parameter int MAX_LEN = lbr_pkg::MAX_LEN_DEF,
  parameter int PW      = $clog2(MAX_LEN + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lbr_pkg::lbr_op_t op,
  input  logic             clr,
  input  logic [PW-1:0]    push_val,
  output logic [PW-1:0]    second,
  output logic             is_base
);
  import lbr_pkg::*;

  localparam int NCELL = MAX_LEN + 1;
  localparam int DW    = $clog2(MAX_LEN + 2);

  logic [PW-1:0] cell_data [NCELL];
  logic [DW-1:0] depth_r;
  logic [DW-1:0] depth_nxt;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    lbr_shift_t    shift;
    logic [PW-1:0] prev_val;
    logic [PW-1:0] next_val;
    logic          cell_clr;

    if (i == 0) begin : g_head
      // The head cell also takes the new base when the stack holds only one entry.
      assign shift.shift_in  = op.push | op.load;
      assign prev_val        = push_val;
      assign cell_clr        = ~rst_n | clr;
    end else begin : g_body
      assign shift.shift_in  = op.push;
      assign prev_val        = cell_data[i-1];
      assign cell_clr        = 1'b0;
    end
    assign shift.shift_out = op.pop;

    if (i == NCELL - 1) begin : g_tail
      assign next_val = cell_data[i];
    end else begin : g_inner
      assign next_val = cell_data[i+1];
    end

    lbr_cell #(.W(PW)) u_cell (
      .clk      (clk),
      .clr      (cell_clr),
      .shift    (shift),
      .prev_val (prev_val),
      .next_val (next_val),
      .data     (cell_data[i])
    );
  end

  always_comb begin
    depth_nxt = depth_r;
    if (clr) begin
      depth_nxt = DW'(1);
    end else if (op.push) begin
      depth_nxt = depth_r + DW'(1);
    end else if (op.pop) begin
      depth_nxt = depth_r - DW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= DW'(1);
    end else begin
      depth_r <= depth_nxt;
    end
  end

  assign second  = cell_data[1];
  assign is_base = (depth_r == DW'(1));

endmodule

// ===== design/longest_valid_bracket_run.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_valid_bracket_run
// Finds the longest well-formed bracket run in a byte string, one byte a beat.
//
//   Channel  Direction  Handshake           Payload
//   in_      input      in_valid/in_ready   in_symbol[7:0], in_last_symbol
//   out_     output     out_valid/out_ready out_max_length[10:0], out_overflow
//
// One input beat is taken every cycle unless a last beat is held back as below;
// each beat does one push, pop or base replacement on the shifting cell chain.
// The result of a string is registered and shows the cycle after its last beat.
// Beats that are not last keep flowing while a result waits; a last beat waits
// only until the held result has been taken.
// Reset clears the head cell and the depth count at once; no clearing pass.
// ----------------------------------------------------------------------------
module longest_valid_bracket_run #(
  parameter int MAX_LEN = lbr_pkg::MAX_LEN_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [lbr_pkg::SYM_W-1:0] in_symbol,
  input  logic                      in_last_symbol,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [lbr_pkg::LEN_W-1:0] out_max_length,
  output logic                      out_overflow
);
  import lbr_pkg::*;

  localparam int PW = $clog2(MAX_LEN + 1);

  logic          accept;
  logic          in_range;
  logic          take;
  logic          str_end;
  logic          is_open;
  logic          is_base;
  lbr_op_t       op;
  logic [PW-1:0] stored;
  logic [PW-1:0] second;
  logic [PW-1:0] run;
  logic          better;
  logic [PW-1:0] best_final;
  logic          ov_final;

  logic [PW-1:0]    pos_r,   pos_nxt;
  logic [PW-1:0]    best_r,  best_nxt;
  logic             ov_r,    ov_nxt;
  logic             ovld_r,  ovld_nxt;
  logic [LEN_W-1:0] olen_r,  olen_nxt;
  logic             oovf_r,  oovf_nxt;

  assign in_ready = ~ovld_r | out_ready | ~in_last_symbol;
  assign accept   = in_valid & in_ready;
  assign in_range = (pos_r < PW'(MAX_LEN));
  assign take     = accept & in_range;
  assign str_end  = accept & in_last_symbol;
  assign is_open  = (in_symbol == OPEN_SYMBOL);
  assign stored   = pos_r + PW'(1);

  assign op.push = take & is_open;
  assign op.pop  = take & ~is_open & ~is_base;
  assign op.load = take & ~is_open & is_base;

  lbr_stack #(.MAX_LEN(MAX_LEN), .PW(PW)) u_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .clr      (str_end),
    .push_val (stored),
    .second   (second),
    .is_base  (is_base)
  );

  // Positions grow along the stack, so the new top never lies past the current byte.
  assign run        = stored - second;
  assign better     = op.pop & (run > best_r);
  assign best_final = better ? run : best_r;
  assign ov_final   = ov_r | (accept & ~in_range);

  always_comb begin
    pos_nxt  = pos_r;
    best_nxt = best_final;
    ov_nxt   = ov_final;
    ovld_nxt = ovld_r & ~out_ready;
    olen_nxt = olen_r;
    oovf_nxt = oovf_r;
    if (take) begin
      pos_nxt = stored;
    end
    if (str_end) begin
      pos_nxt  = '0;
      best_nxt = '0;
      ov_nxt   = 1'b0;
      ovld_nxt = 1'b1;
      olen_nxt = ov_final ? '0 : LEN_W'(best_final);
      oovf_nxt = ov_final;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      best_r <= '0;
      ov_r   <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      best_r <= best_nxt;
      ov_r   <= ov_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    olen_r <= olen_nxt;
    oovf_r <= oovf_nxt;
  end

  assign out_valid      = ovld_r;
  assign out_max_length = olen_r;
  assign out_overflow   = oovf_r;

`ifndef SYNTHESIS
  a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last_symbol) |=> out_valid)
    else $error("no result after the last beat of a string");

  a_overflow_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> (out_max_length == '0))
    else $error("overflowed string reports a nonzero length");

  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PW'(MAX_LEN))
    else $error("byte position ran past the string limit");

  a_best_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    best_r <= pos_r)
    else $error("best run is longer than the bytes taken");
`endif

endmodule

// ===== dv/tb_longest_valid_bracket_run.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_longest_valid_bracket_run
// Streams byte strings into the bracket run finder and checks each string's
// result against a stack-based scan kept in the bench. Both channels idle at
// random. Strings cover short directed cases and random mixes of balanced
// blocks, stray brackets and arbitrary bytes.
// ----------------------------------------------------------------------------
module tb_longest_valid_bracket_run;
  import lbr_pkg::*;

  localparam int MAX_LEN      = MAX_LEN_DEF;
  localparam int RANDOM_ITEMS = 400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [SYM_W-1:0] sym;
    logic             last;
  } sym_beat_t;

  typedef struct {
    logic [LEN_W-1:0] max_length;
    logic             overflow;
  } run_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [SYM_W-1:0]     in_symbol = '0;
  logic                 in_last_symbol = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [LEN_W-1:0]     out_max_length;
  logic                 out_overflow;

  sym_beat_t            symbol_queue[$];
  run_result_t          expected_runs[$];
  logic [SYM_W-1:0]     draft[$];

  // Bench copy of the scan state.
  logic [LEN_W-1:0]     pos_stack [0:MAX_LEN];
  int unsigned          stack_depth;
  int unsigned          scan_pos;
  int unsigned          best_run;
  logic                 too_long;

  int                   send_gap = 0;
  int                   send_calm = 0;
  int                   stall_left = 0;
  int                   stall_calm = 0;
  int                   errors = 0;
  int                   cycle_count = 0;
  int                   random_items = 0;

  longest_valid_bracket_run #(.MAX_LEN(MAX_LEN)) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_symbol     (in_symbol),
    .in_last_symbol(in_last_symbol),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_max_length(out_max_length),
    .out_overflow  (out_overflow)
  );

  always #5 clk = ~clk;

  function automatic void clear_scan();
    pos_stack[0] = '0;
    stack_depth  = 1;
    scan_pos     = 0;
    best_run     = 0;
    too_long     = 1'b0;
  endfunction

  function automatic void push_pos(int unsigned tag);
    if (stack_depth < MAX_LEN + 1) begin
      pos_stack[stack_depth] = tag[LEN_W-1:0];
      stack_depth++;
    end
  endfunction

  // Positions are kept offset by one so that the base below the string is 0.
  function automatic void scan_symbol(logic [SYM_W-1:0] sym, logic last);
    int unsigned tag;
    int unsigned top;
    run_result_t res;
    if (scan_pos >= MAX_LEN) begin
      too_long = 1'b1;
    end else begin
      tag = scan_pos + 1;
      if (sym == OPEN_SYMBOL) begin
        push_pos(tag);
      end else begin
        if (stack_depth > 0) stack_depth--;
        if (stack_depth > 0) begin
          top = pos_stack[stack_depth-1];
          if (top <= tag && tag - top > best_run) best_run = tag - top;
        end else begin
          push_pos(tag);
        end
      end
      scan_pos++;
    end
    if (last) begin
      res.max_length = too_long ? '0 : best_run[LEN_W-1:0];
      res.overflow   = too_long;
      expected_runs.push_back(res);
      clear_scan();
    end
  endfunction

  // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SYM_W-1:0] any_closer();
    logic [SYM_W-1:0] b;
    b = SYM_W'($urandom_range(0, 255));
    if (b == OPEN_SYMBOL) b = b ^ 8'h01;
    return b;
  endfunction

  function automatic logic [SYM_W-1:0] pick_closer();
    if ($urandom_range(0, 4) != 0) return 8'h29;
    return any_closer();
  endfunction

  task automatic end_draft();
    sym_beat_t beat;
    for (int i = 0; i < draft.size(); i++) begin
      beat.sym  = draft[i];
      beat.last = (i == draft.size() - 1);
      symbol_queue.push_back(beat);
    end
    draft.delete();
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
    end_draft();
  endtask

  task automatic add_balanced();
    int opens;
    int closes;
    int depth;
    opens  = $urandom_range(1, 8);
    closes = opens;
    depth  = 0;
    while (opens + closes > 0) begin
      if (opens > 0 && (depth == 0 || $urandom_range(0, 1) == 1)) begin
        draft.push_back(OPEN_SYMBOL);
        opens--;
        depth++;
      end else begin
        draft.push_back(pick_closer());
        closes--;
        depth--;
      end
    end
  endtask

  task automatic add_random_string();
    int kind;
    int segs;
    int len;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      segs = $urandom_range(1, 4);
      repeat (segs) begin
        kind = $urandom_range(0, 99);
        if (kind < 60) add_balanced();
        else if (kind < 85) draft.push_back(pick_closer());
        else draft.push_back(OPEN_SYMBOL);
      end
    end else if (kind < 85) begin
      len = $urandom_range(1, 20);
      repeat (len) draft.push_back($urandom_range(0, 1) ? OPEN_SYMBOL : pick_closer());
    end else begin
      len = $urandom_range(1, 20);
      repeat (len) draft.push_back(SYM_W'($urandom_range(0, 255)));
    end
    random_items += draft.size();
    end_draft();
  endtask

  // Driver: the beat on the bus is scanned in the cycle it is taken.
  always @(posedge clk) begin
    sym_beat_t beat;
    if (!rst_n) begin
      in_valid       <= 1'b0;
      in_symbol      <= '0;
      in_last_symbol <= 1'b0;
    end else begin
      if (in_valid && in_ready) scan_symbol(in_symbol, in_last_symbol);
      if (!(in_valid && !in_ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (symbol_queue.size() > 0) begin
          beat = symbol_queue.pop_front();
          in_symbol      <= beat.sym;
          in_last_symbol <= beat.last;
          in_valid       <= 1'b1;
          send_gap = pick_gap(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat and stalls the output at random.
  always @(posedge clk) begin
    run_result_t exp;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_runs.size() == 0) begin
          $display("%0t: result with none expected: max_length %0d, overflow %0b",
                   $time, out_max_length, out_overflow);
          errors++;
        end else begin
          exp = expected_runs.pop_front();
          if (out_max_length !== exp.max_length) begin
            $display("%0t: max_length expected %0d, got %0d",
                     $time, exp.max_length, out_max_length);
            errors++;
          end
          if (out_overflow !== exp.overflow) begin
            $display("%0t: overflow expected %0b, got %0b",
                     $time, exp.overflow, out_overflow);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 9) == 0) stall_left = pick_gap(stall_calm);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("longest_valid_bracket_run test failed");
      $finish;
    end
  end

  initial begin
    clear_scan();

    // Short directed strings, including a lone opener and a lone closer.
    add_text("()");
    add_text("(");
    add_text(")");
    add_text(")()())");
    add_text("(()");
    add_text("()(())");
    // Any byte other than the opener closes, the extreme byte values included.
    draft.push_back(OPEN_SYMBOL);
    draft.push_back(8'hFF);
    draft.push_back(OPEN_SYMBOL);
    draft.push_back(8'h00);
    end_draft();

    while (random_items < RANDOM_ITEMS) add_random_string();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (symbol_queue.size() != 0 || in_valid) @(posedge clk);
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("longest_valid_bracket_run test passed");
    end else begin
      $display("longest_valid_bracket_run test failed");
    end
    $finish;
  end

endmodule
